@@ rtl/v3au_pkg.sv @@
// Shared types and constants for the three-component vector arithmetic unit.
// Holds the request and result payload structs, operation and status codes.
// No dependencies.
package v3au_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int PORT_BITS     = 32;

  localparam logic [PORT_BITS-1:0] SCALE_RESET = 32'h0001_0000;

  typedef enum logic [2:0] {
    OP_DOT   = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_CROSS = 3'd3,
    OP_SCALE = 3'd4,
    OP_LEN   = 3'd5,
    OP_NORM  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    op_t                         operation;
    logic signed [PORT_BITS-1:0] a_x;
    logic signed [PORT_BITS-1:0] a_y;
    logic signed [PORT_BITS-1:0] a_z;
    logic signed [PORT_BITS-1:0] b_x;
    logic signed [PORT_BITS-1:0] b_y;
    logic signed [PORT_BITS-1:0] b_z;
  } req_t;

  typedef struct packed {
    logic signed [PORT_BITS-1:0] res_x;
    logic signed [PORT_BITS-1:0] res_y;
    logic signed [PORT_BITS-1:0] res_z;
    status_t                     status;
  } res_t;

endpackage

@@ rtl/v3au_lane.sv @@
// One component lane: operand select, two registered multipliers, then the
// per-component add, subtract, cross and scale result. Depends on v3au_pkg.
module v3au_lane #(
  parameter int WORD_BITS = v3au_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = v3au_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  v3au_pkg::op_t                op,
  input  logic signed [WORD_BITS-1:0]  a_i,
  input  logic signed [WORD_BITS-1:0]  a_j,
  input  logic signed [WORD_BITS-1:0]  a_k,
  input  logic signed [WORD_BITS-1:0]  b_i,
  input  logic signed [WORD_BITS-1:0]  b_j,
  input  logic signed [WORD_BITS-1:0]  b_k,
  input  logic signed [WORD_BITS-1:0]  sf,
  output logic signed [2*WORD_BITS-1:0] prod,
  output logic signed [2*WORD_BITS+1:0] val
);
  import v3au_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int RW = 2 * WORD_BITS + 2;

  logic signed [W-1:0]   ma, mb;
  logic signed [2*W-1:0] prod2;
  logic signed [2*W:0]   diff;
  logic signed [W-1:0]   a2, b2;
  op_t                   op2;
  logic signed [RW-1:0]  val_next;

  always_comb begin
    ma = a_i;
    mb = a_i;
    case (op)
      OP_DOT: begin
        mb = b_i;
      end
      OP_CROSS: begin
        ma = a_j;
        mb = b_k;
      end
      OP_SCALE: begin
        mb = sf;
      end
      default: begin
        mb = a_i;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= ma * mb;
      prod2 <= a_k * b_j;
      op2   <= op;
      a2    <= a_i;
      b2    <= b_i;
    end
  end

  assign diff = (2*W+1)'(prod) - (2*W+1)'(prod2);

  always_comb begin
    case (op2)
      OP_ADD:   val_next = RW'(a2) + RW'(b2);
      OP_SUB:   val_next = RW'(a2) - RW'(b2);
      OP_CROSS: val_next = RW'(diff >>> FRAC_BITS);
      OP_SCALE: val_next = RW'(prod >>> FRAC_BITS);
      default:  val_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val <= val_next;
    end
  end

endmodule

@@ rtl/v3au_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on v3au_pkg for default widths.
module v3au_sqrt #(
  parameter int WORD_BITS = v3au_pkg::WORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [2*WORD_BITS-1:0] rad,
  output logic [WORD_BITS-1:0]   root
);
  import v3au_pkg::*;

  localparam int W = WORD_BITS;

  logic [W-1:0]   rem_q  [W];
  logic [W-1:0]   root_q [W];
  logic [2*W-1:0] rad_q  [W];

  for (genvar g = 0; g < W; g++) begin : g_stage
    logic [W-1:0]   rin, qin;
    logic [2*W-1:0] din;
    logic [W+1:0]   r2, t, rn;
    logic           ge;

    if (g == 0) begin : g_first
      assign rin = '0;
      assign qin = '0;
      assign din = rad;
    end else begin : g_next
      assign rin = rem_q[g-1];
      assign qin = root_q[g-1];
      assign din = rad_q[g-1];
    end

    assign r2 = {rin, din[2*W-1 -: 2]};
    assign t  = {qin, 2'b01};
    assign ge = (r2 >= t);
    assign rn = ge ? (r2 - t) : r2;

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[g] <= {qin[W-2:0], ge};
      end
    end

    if (g < W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[g] <= rn[W-1:0];
          rad_q[g] <= din << 2;
        end
      end
    end
  end

  assign root = root_q[W-1];

endmodule

@@ rtl/v3au_div.sv @@
// Pipelined restoring divider for normalise: (mag << FRAC_BITS) / den,
// one quotient bit per stage, given mag <= den. Depends on v3au_pkg.
module v3au_div #(
  parameter int WORD_BITS = v3au_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = v3au_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [WORD_BITS-1:0] mag,
  input  logic [WORD_BITS-1:0] den,
  output logic [FRAC_BITS:0]   quo
);
  import v3au_pkg::*;

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;

  logic [W-1:0] rem_q [F+1];
  logic [W-1:0] den_q [F+1];
  logic [F:0]   q_q   [F+1];

  for (genvar g = 0; g <= F; g++) begin : g_stage
    logic [W-1:0] rin, dn;
    logic [F:0]   qin;
    logic         bin, ge;
    logic [W:0]   r2, rn;

    if (g == 0) begin : g_first
      assign rin = {1'b0, mag[W-1:1]};
      assign bin = mag[0];
      assign qin = '0;
      assign dn  = den;
    end else begin : g_next
      assign rin = rem_q[g-1];
      assign bin = 1'b0;
      assign qin = q_q[g-1];
      assign dn  = den_q[g-1];
    end

    assign r2 = {rin, bin};
    assign ge = (r2 >= {1'b0, dn});
    assign rn = ge ? (r2 - {1'b0, dn}) : r2;

    always_ff @(posedge clk) begin
      if (en) begin
        q_q[g] <= {qin[F-1:0], ge};
      end
    end

    if (g < F) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[g] <= rn[W-1:0];
          den_q[g] <= dn;
        end
      end
    end
  end

  assign quo = q_q[F];

endmodule

@@ rtl/vector3_arithmetic_unit_top.sv @@
// Three-component vector ALU: dot, add, subtract, cross, scale, length and
// normalise on signed fixed-point vectors, with saturation and status.
// Takes one request per clock while op_stall is low. Its depth comes from
// the one-bit-per-stage square root (WORD_BITS stages) followed by the
// normalise divider (FRAC_BITS + 1 stages); Q16.16 by default. Every
// operation travels the full pipeline so results leave in request order.
// A two-entry output buffer lets requests keep entering while a result
// waits; stall rises only once both entries are full.
module vector3_arithmetic_unit_top #(
  parameter int FRAC_BITS = v3au_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = v3au_pkg::WORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              op_valid,
  output logic                              op_stall,
  input  v3au_pkg::req_t                    op_data,
  output logic                              res_valid,
  input  logic                              res_stall,
  output v3au_pkg::res_t                    res_data,
  input  logic                              cfg_we,
  input  logic [v3au_pkg::PORT_BITS-1:0]    cfg_data
);
  import v3au_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int RW = 2 * WORD_BITS + 2;
  localparam logic signed [RW-1:0] SMAX = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [RW-1:0] SMIN = ~SMAX;

  logic                 en;
  logic [PORT_BITS-1:0] scale;

  // request register
  logic                v1;
  op_t                 op1;
  logic signed [W-1:0] a1 [3];
  logic signed [W-1:0] b1 [3];
  logic [W-1:0]        mag1 [3];
  logic                neg1 [3];

  // multiply and lane stages
  logic                  v2, v3;
  op_t                   op2, op3;
  logic [W-1:0]          mag2 [3], mag3 [3];
  logic                  neg2 [3], neg3 [3];
  logic signed [2*W-1:0] prod [3];
  logic signed [RW-1:0]  val  [3];
  logic signed [RW-1:0]  s3;
  logic [W-1:0]          root;

  // alongside the square root
  logic [W-1:0]         da_v;
  op_t                  da_op  [W];
  logic signed [RW-1:0] da_r   [W][3];
  logic [W-1:0]         da_mag [W][3];
  logic                 da_neg [W][3];

  // alongside the divider
  logic [F:0]           db_v;
  op_t                  db_op   [F+1];
  logic signed [RW-1:0] db_r    [F+1][3];
  logic                 db_neg  [F+1][3];
  logic                 db_zero [F+1];
  logic [F:0]           quo [3];

  logic signed [RW-1:0] fin_r [3];
  logic [W-1:0]         fin_c [3];
  logic [2:0]           fin_sat;
  res_t                 fin;
  logic                 skid_v;
  res_t                 skid_d;
  logic                 take;

  assign en       = !skid_v;
  assign op_stall = skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_we) begin
      scale <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      da_v <= '0;
      db_v <= '0;
    end else if (en) begin
      v1   <= op_valid;
      v2   <= v1;
      v3   <= v2;
      da_v <= {da_v[W-2:0], v3};
      db_v <= {db_v[F-1:0], da_v[W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1   <= op_data.operation;
      a1[0] <= op_data.a_x[W-1:0];
      a1[1] <= op_data.a_y[W-1:0];
      a1[2] <= op_data.a_z[W-1:0];
      b1[0] <= op_data.b_x[W-1:0];
      b1[1] <= op_data.b_y[W-1:0];
      b1[2] <= op_data.b_z[W-1:0];
      op2   <= op1;
      op3   <= op2;
      s3    <= RW'(prod[0]) + RW'(prod[1]) + RW'(prod[2]);
      for (int i = 0; i < 3; i++) begin
        mag2[i] <= mag1[i];
        mag3[i] <= mag2[i];
        neg2[i] <= neg1[i];
        neg3[i] <= neg2[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg1[i] = a1[i][W-1];
      mag1[i] = a1[i][W-1] ? (~a1[i] + 1'b1) : a1[i];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3au_lane #(
      .WORD_BITS(W),
      .FRAC_BITS(F)
    ) u_lane (
      .clk  (clk),
      .en   (en),
      .op   (op1),
      .a_i  (a1[i]),
      .a_j  (a1[(i+1)%3]),
      .a_k  (a1[(i+2)%3]),
      .b_i  (b1[i]),
      .b_j  (b1[(i+1)%3]),
      .b_k  (b1[(i+2)%3]),
      .sf   (scale[W-1:0]),
      .prod (prod[i]),
      .val  (val[i])
    );
  end

  v3au_sqrt #(
    .WORD_BITS(W)
  ) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (s3[2*W-1:0]),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      da_op[0]   <= op3;
      da_r[0][0] <= (op3 == OP_DOT) ? (s3 >>> F) : val[0];
      da_r[0][1] <= val[1];
      da_r[0][2] <= val[2];
      for (int i = 0; i < 3; i++) begin
        da_mag[0][i] <= mag3[i];
        da_neg[0][i] <= neg3[i];
      end
      for (int k = 1; k < W; k++) begin
        da_op[k] <= da_op[k-1];
        for (int i = 0; i < 3; i++) begin
          da_r[k][i]   <= da_r[k-1][i];
          da_mag[k][i] <= da_mag[k-1][i];
          da_neg[k][i] <= da_neg[k-1][i];
        end
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3au_div #(
      .WORD_BITS(W),
      .FRAC_BITS(F)
    ) u_div (
      .clk (clk),
      .en  (en),
      .mag (da_mag[W-1][i]),
      .den (root),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      db_op[0]   <= da_op[W-1];
      db_zero[0] <= (root == '0);
      db_r[0][0] <= (da_op[W-1] == OP_LEN) ? RW'(root) : da_r[W-1][0];
      db_r[0][1] <= da_r[W-1][1];
      db_r[0][2] <= da_r[W-1][2];
      for (int i = 0; i < 3; i++) begin
        db_neg[0][i] <= da_neg[W-1][i];
      end
      for (int k = 1; k <= F; k++) begin
        db_op[k]   <= db_op[k-1];
        db_zero[k] <= db_zero[k-1];
        for (int i = 0; i < 3; i++) begin
          db_r[k][i]   <= db_r[k-1][i];
          db_neg[k][i] <= db_neg[k-1][i];
        end
      end
    end
  end

  // merge: normalise select, saturation, status
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (db_op[F] == OP_NORM) begin
        if (db_zero[F]) begin
          fin_r[i] = '0;
        end else if (db_neg[F][i]) begin
          fin_r[i] = -RW'(quo[i]);
        end else begin
          fin_r[i] = RW'(quo[i]);
        end
      end else begin
        fin_r[i] = db_r[F][i];
      end
      fin_sat[i] = 1'b0;
      if (fin_r[i] > SMAX) begin
        fin_c[i]   = SMAX[W-1:0];
        fin_sat[i] = 1'b1;
      end else if (fin_r[i] < SMIN) begin
        fin_c[i]   = SMIN[W-1:0];
        fin_sat[i] = 1'b1;
      end else begin
        fin_c[i] = fin_r[i][W-1:0];
      end
    end
    fin.res_x = PORT_BITS'(signed'(fin_c[0]));
    fin.res_y = PORT_BITS'(signed'(fin_c[1]));
    fin.res_z = PORT_BITS'(signed'(fin_c[2]));
    if (db_op[F] == OP_NORM && db_zero[F]) begin
      fin.status = ST_ZERO;
    end else if (fin_sat != 3'b000) begin
      fin.status = ST_SAT;
    end else begin
      fin.status = ST_OK;
    end
  end

  // output register plus skid entry
  assign take = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!skid_v) begin
      if (!res_valid || take) begin
        res_valid <= db_v[F];
        res_data  <= fin;
      end else if (db_v[F]) begin
        skid_v <= 1'b1;
        skid_d <= fin;
      end
    end else if (take) begin
      res_data <= skid_d;
      skid_v   <= 1'b0;
    end
  end

endmodule
